[hdl/md2_hash_variable_rounds_unit_assert.svh]
// assertion macros for the md2 hash unit
`ifndef MD2_HASH_VARIABLE_ROUNDS_UNIT_ASSERT_SVH
`define MD2_HASH_VARIABLE_ROUNDS_UNIT_ASSERT_SVH

// property that holds at every edge outside reset
`define MD2_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define MD2_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/md2_pkg.sv]
// package with transaction types and the substitution table of the md2 hash unit
package md2_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int STATE_BYTES = 48;
   localparam logic [7:0] ROUND_COUNT_RESET = 8'd18;

   typedef struct packed {
      logic       action;
      logic [7:0] message_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] digest_byte;
      logic [3:0] digest_index;
      logic       digest_last;
   } rsp_type;

   localparam logic [7:0] SBOX [0:255] = '{
      8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
      8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
      8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
      8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
      8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
      8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
      8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
      8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
      8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
      8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
      8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
      8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
      8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
      8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
      8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
      8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
      8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
      8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
      8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
      8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
      8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
      8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
      8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
      8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
      8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
      8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
      8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
      8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
      8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
      8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
      8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
      8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
   };

endpackage

[hdl/md2_hash_variable_rounds_unit.sv]
// md2 hash unit with a programmable round count, byte-serial datapath
//
// Usage: each req transaction carries one message byte (action 0) or a finish
// command (action 1). A finish pads the open block, compresses it, compresses
// the checksum and then offers the 16 digest bytes on rsp, index 0 first,
// digest_last set on index 15. The csr channel writes round_count (18 = MD2).
// Timing: the mix state, checksum and block are byte shift registers, and one
// byte passes the substitution table per cycle. The byte that fills a block
// starts a compression: a load pass over the 16 block bytes, then
// round_count rounds over the 48-byte state. A finish pads the open block
// with 16 - fill pad bytes, runs two compressions (block, then checksum),
// then offers 16 digest transactions. req_stall stays high until the
// previous transaction is fully done.
// Reset: mix state, checksum and fill clear to zero, round_count returns to 18.
// A stalled rsp holds its byte; the unit waits and loses nothing. After the
// last digest byte the hash returns to its cleared state.
`include "md2_hash_variable_rounds_unit_assert.svh"

module md2_hash_variable_rounds_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  md2_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output md2_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   localparam int SB = md2_pkg::BLOCK_BYTES;
   localparam int SS = md2_pkg::STATE_BYTES;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [3:0] fill_ff, fill_in;
   logic [7:0] rounds_ff, rounds_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [7:0] rnd_ff, rnd_in;
   logic [7:0] t_ff, t_in;
   logic [7:0] pad_ff, pad_in;
   logic       fin_ff, fin_in;
   logic       src_cs_ff, src_cs_in;
   logic [7:0] st_ff [SS];
   logic [7:0] st_in [SS];
   logic [7:0] cs_ff [SB];
   logic [7:0] cs_in [SB];
   logic [7:0] bb_ff [SB];
   logic [7:0] bb_in [SB];

   logic       req_fire, rsp_fire, cmp_done;
   logic [7:0] m_byte, mix_x, cs_new;

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   // result transaction straight from the head of the mix state
   assign rsp_data.digest_byte  = st_ff[0];
   assign rsp_data.digest_index = cnt_ff[3:0];
   assign rsp_data.digest_last  = (cnt_ff[3:0] == 4'd15);

   // byte-wide datapath: block byte, round mix and checksum byte
   assign m_byte = src_cs_ff ? cs_ff[0] : bb_ff[0];
   assign mix_x  = st_ff[0] ^ md2_pkg::SBOX[t_ff];
   assign cs_new = cs_ff[0] ^ md2_pkg::SBOX[m_byte ^ cs_ff[15]];

   // next state
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      rounds_in = rounds_ff;
      cnt_in    = cnt_ff;
      rnd_in    = rnd_ff;
      t_in      = t_ff;
      pad_in    = pad_ff;
      fin_in    = fin_ff;
      src_cs_in = src_cs_ff;
      st_in     = st_ff;
      cs_in     = cs_ff;
      bb_in     = bb_ff;
      cmp_done  = 1'b0;

      if (csr_valid && csr_ready) begin
         rounds_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.action) begin
                  fin_in    = 1'b1;
                  src_cs_in = 1'b0;
                  pad_in    = {3'b000, 5'd16 - {1'b0, fill_ff}};
                  state_in  = ST_PAD;
               end else begin
                  for (int i = 0; i < SB - 1; i++) bb_in[i] = bb_ff[i + 1];
                  bb_in[SB - 1] = req_data.message_byte;
                  fill_in = fill_ff + 4'd1;
                  if (fill_ff == 4'd15) begin
                     fin_in    = 1'b0;
                     src_cs_in = 1'b0;
                     cnt_in    = '0;
                     t_in      = '0;
                     state_in  = ST_LOAD;
                  end
               end
            end
         end
         ST_PAD: begin
            for (int i = 0; i < SB - 1; i++) bb_in[i] = bb_ff[i + 1];
            bb_in[SB - 1] = pad_ff;
            fill_in = fill_ff + 4'd1;
            if (fill_ff == 4'd15) begin
               cnt_in   = '0;
               t_in     = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // first third rotates, second takes the block, third its xor
            for (int i = 0; i < SB - 1; i++) begin
               st_in[i]          = st_ff[i + 1];
               st_in[SB + i]     = st_ff[SB + i + 1];
               st_in[2 * SB + i] = st_ff[2 * SB + i + 1];
            end
            st_in[SB - 1]     = st_ff[0];
            st_in[2 * SB - 1] = m_byte;
            st_in[SS - 1]     = m_byte ^ st_ff[0];
            for (int i = 0; i < SB - 1; i++) begin
               bb_in[i] = bb_ff[i + 1];
               cs_in[i] = cs_ff[i + 1];
            end
            bb_in[SB - 1] = bb_ff[0];
            cs_in[SB - 1] = src_cs_ff ? cs_ff[0] : cs_new;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(SB - 1)) begin
               cnt_in = '0;
               rnd_in = '0;
               if (rounds_ff == 8'd0) begin
                  cmp_done = 1'b1;
               end else begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            // one substitution per cycle around the 48 byte ring
            for (int i = 0; i < SS - 1; i++) st_in[i] = st_ff[i + 1];
            st_in[SS - 1] = mix_x;
            t_in   = mix_x;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(SS - 1)) begin
               cnt_in = '0;
               t_in   = mix_x + rnd_ff;
               rnd_in = rnd_ff + 8'd1;
               if (rnd_ff == rounds_ff - 8'd1) begin
                  cmp_done = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               for (int i = 0; i < SS - 1; i++) st_in[i] = st_ff[i + 1];
               st_in[SS - 1] = st_ff[0];
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[3:0] == 4'd15) begin
                  for (int i = 0; i < SS; i++) st_in[i] = '0;
                  for (int i = 0; i < SB; i++) cs_in[i] = '0;
                  cnt_in    = '0;
                  fin_in    = 1'b0;
                  src_cs_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // sequencing after a compression
      if (cmp_done) begin
         cnt_in = '0;
         if (!fin_ff) begin
            state_in = ST_IDLE;
         end else if (!src_cs_ff) begin
            src_cs_in = 1'b1;
            t_in      = '0;
            state_in  = ST_LOAD;
         end else begin
            state_in = ST_EMIT;
         end
      end
   end

   // control and hash state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         rounds_ff <= md2_pkg::ROUND_COUNT_RESET;
         cnt_ff    <= '0;
         fin_ff    <= 1'b0;
         src_cs_ff <= 1'b0;
         for (int i = 0; i < SS; i++) st_ff[i] <= '0;
         for (int i = 0; i < SB; i++) cs_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         rounds_ff <= rounds_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
         src_cs_ff <= src_cs_in;
         st_ff     <= st_in;
         cs_ff     <= cs_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      t_ff   <= t_in;
      pad_ff <= pad_in;
      bb_ff  <= bb_in;
   end

   // checks
   `MD2_ASSERT(a_emit_fill_zero, (state_ff != ST_EMIT) || (fill_ff == 4'd0),
      "block fill not zero while emitting digest")
   `MD2_ASSERT(a_cnt_range, (state_ff != ST_ROUND) || (cnt_ff < 6'(SS)),
      "round byte counter out of range")
   `MD2_ASSERT(a_cs_pass_in_finish, !src_cs_ff || fin_ff,
      "checksum compression outside a finish")
   `MD2_ASSERT_NEXT(a_clear_after_last, rsp_fire && rsp_data.digest_last,
      (state_ff == ST_IDLE) && (cs_ff[SB - 1] == 8'd0) && (st_ff[0] == 8'd0),
      "hash not cleared after last digest byte")

endmodule
